FILE: rtl/core/etdc_pkg.sv
// shared types, constants and saturating helpers for the dense code decoder
package etdc_pkg;

  localparam int TABLE_DEPTH = 65536;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int CQ_DEPTH    = 4;
  localparam int CQ_AW       = $clog2(CQ_DEPTH);
  localparam int OQ_DEPTH    = 4;
  localparam int OQ_AW       = $clog2(OQ_DEPTH);

  localparam logic [7:0]  END_MARK   = 8'd128;
  localparam logic [31:0] SAT_MAX    = 32'hFFFF_FFFF;
  localparam logic [31:0] WEIGHT_RST = 32'd128;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // one operation for the back end: a table write or a table lookup
  typedef struct packed {
    logic        wr;
    logic        err;
    logic [31:0] idx;
    logic [31:0] word;
  } cmd_t;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] idx;
    logic        err;
  } res_t;

  function automatic logic [31:0] sat_mul128(input logic [31:0] a);
    logic [31:0] r;
    if (a[31:25] != 7'd0) begin
      r = SAT_MAX;
    end else begin
      r = {a[24:0], 7'd0};
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT_MAX : s[31:0];
  endfunction

endpackage

FILE: rtl/core/end_tagged_dense_code_decoder_unit.sv
// top level of the end-tagged dense code decoder
// Takes one item per clock unless full: a vocabulary load (mode 0) or one code byte (mode 1).
// Bytes below 128 extend the current codeword; a byte of 128 or more ends it and yields one result
// with the dense index (saturated at all ones), the vocabulary word, or zero with index_error set
// when the index is not below vocabulary_size or 65536. A result passes the operation queue, lookup
// register and result queue. Sustained rate is one item per cycle when no queue stalls, set by the
// single-port vocabulary memory that serves one load or one lookup each cycle; four-entry operation
// and result queues let input and output stall independently. Table entries are undefined until
// loaded; there is no clearing pass after reset. Write vocabulary_size only while the block is idle.
module end_tagged_dense_code_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic        in_mode,
  input  logic [15:0] in_entry_index,
  input  logic [31:0] in_entry_word,
  input  logic [7:0]  in_code_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_decoded_word,
  output logic [31:0] out_code_index,
  output logic        out_index_error
);

  logic [16:0]    vocab_size_r;
  logic           in_xfer;
  logic           cmd_vld;
  etdc_pkg::cmd_t cmd;
  logic           cq_empty;
  logic           cq_pop;
  etdc_pkg::cmd_t cq_head;
  logic           res_pop;
  etdc_pkg::res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vocab_size_r <= '0;
    end else if (cfg_we) begin
      vocab_size_r <= cfg_wdata;
    end
  end

  assign in_xfer = push && !full;
  assign res_pop = pop && !empty;

  etdc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc_i         (in_xfer),
    .mode_i        (in_mode),
    .entry_index_i (in_entry_index),
    .entry_word_i  (in_entry_word),
    .code_byte_i   (in_code_byte),
    .vocab_size_i  (vocab_size_r),
    .cmd_vld_o     (cmd_vld),
    .cmd_o         (cmd)
  );

  etdc_cmd_q u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (cmd_vld),
    .data_i  (cmd),
    .full_o  (full),
    .pop_i   (cq_pop),
    .empty_o (cq_empty),
    .head_o  (cq_head)
  );

  etdc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cq_empty_i  (cq_empty),
    .cq_head_i   (cq_head),
    .cq_pop_o    (cq_pop),
    .res_empty_o (empty),
    .res_pop_i   (res_pop),
    .res_o       (res)
  );

  assign out_decoded_word = res.word;
  assign out_code_index   = res.idx;
  assign out_index_error  = res.err;

endmodule

FILE: rtl/core/etdc_front.sv
// front end: codeword state, dense index and error classification
module etdc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc_i,
  input  logic               mode_i,
  input  logic [15:0]        entry_index_i,
  input  logic [31:0]        entry_word_i,
  input  logic [7:0]         code_byte_i,
  input  logic [16:0]        vocab_size_i,
  output logic               cmd_vld_o,
  output etdc_pkg::cmd_t     cmd_o
);

  logic [31:0] acc_r, acc_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] weight_r, weight_nxt;
  logic [31:0] acc_sh;
  logic [31:0] idx;
  logic        is_end;

  assign acc_sh = etdc_pkg::sat_mul128(acc_r);
  assign is_end = (code_byte_i >= etdc_pkg::END_MARK);
  assign idx    = etdc_pkg::sat_add(etdc_pkg::sat_add(acc_sh, base_r),
                                    {25'd0, code_byte_i[6:0]});

  always_comb begin
    acc_nxt    = acc_r;
    base_nxt   = base_r;
    weight_nxt = weight_r;
    cmd_vld_o  = 1'b0;
    cmd_o.wr   = 1'b0;
    cmd_o.err  = 1'b0;
    cmd_o.idx  = idx;
    cmd_o.word = entry_word_i;
    if (acc_i) begin
      if (mode_i == etdc_pkg::MODE_LOAD) begin
        cmd_vld_o = 1'b1;
        cmd_o.wr  = 1'b1;
        cmd_o.idx = 32'(entry_index_i);
        // out-of-range writes travel as dropped operations
        cmd_o.err = (32'(entry_index_i) >= 32'(etdc_pkg::TABLE_DEPTH));
      end else if (!is_end) begin
        acc_nxt    = etdc_pkg::sat_add(acc_sh, {24'd0, code_byte_i});
        base_nxt   = etdc_pkg::sat_add(base_r, weight_r);
        weight_nxt = etdc_pkg::sat_mul128(weight_r);
      end else begin
        cmd_vld_o  = 1'b1;
        cmd_o.err  = (idx >= {15'd0, vocab_size_i}) ||
                     (idx >= 32'(etdc_pkg::TABLE_DEPTH));
        acc_nxt    = '0;
        base_nxt   = '0;
        weight_nxt = etdc_pkg::WEIGHT_RST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      base_r   <= '0;
      weight_r <= etdc_pkg::WEIGHT_RST;
    end else begin
      acc_r    <= acc_nxt;
      base_r   <= base_nxt;
      weight_r <= weight_nxt;
    end
  end

  // the weight is always a power of 128 or saturated
  a_weight_form: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(weight_r) || (weight_r == etdc_pkg::SAT_MAX))
    else $error("length weight lost its form");

  // a finished codeword restarts the digit state
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_i && mode_i == etdc_pkg::MODE_DECODE && is_end) |=>
      (acc_r == '0 && base_r == '0 && weight_r == etdc_pkg::WEIGHT_RST))
    else $error("codeword state not cleared after end byte");

endmodule

FILE: rtl/core/etdc_cmd_q.sv
// short operation queue between front end and back end
module etdc_cmd_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  etdc_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output etdc_pkg::cmd_t head_o
);

  etdc_pkg::cmd_t                mem_r [etdc_pkg::CQ_DEPTH];
  logic [etdc_pkg::CQ_AW-1:0]    wp_r, rp_r;
  logic [etdc_pkg::CQ_AW:0]      cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == (etdc_pkg::CQ_AW + 1)'(etdc_pkg::CQ_DEPTH));
  assign empty_o = (cnt_r == '0);
  assign head_o  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_i) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop_i) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wp_r] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("operation queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("operation queue underflow");

endmodule

FILE: rtl/core/etdc_back.sv
// back end: vocabulary memory, registered lookup and result queue
module etdc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cq_empty_i,
  input  etdc_pkg::cmd_t cq_head_i,
  output logic           cq_pop_o,
  output logic           res_empty_o,
  input  logic           res_pop_i,
  output etdc_pkg::res_t res_o
);

  logic [31:0]                vocab_mem [etdc_pkg::TABLE_DEPTH];
  logic [31:0]                rd_data_r;
  logic                       s1_vld_r;
  logic [31:0]                s1_idx_r;
  logic                       s1_err_r;

  etdc_pkg::res_t             oq_r [etdc_pkg::OQ_DEPTH];
  logic [etdc_pkg::OQ_AW-1:0] oq_wp_r, oq_rp_r;
  logic [etdc_pkg::OQ_AW:0]   oq_cnt_r, oq_cnt_nxt;
  logic [etdc_pkg::OQ_AW:0]   oq_used;
  logic                       credit;
  logic                       issue_rd;
  logic                       issue_wr;
  logic [etdc_pkg::TBL_AW-1:0] addr;
  etdc_pkg::res_t             s1_res;

  // slots taken or promised, counting the lookup in flight
  assign oq_used  = oq_cnt_r + {{etdc_pkg::OQ_AW{1'b0}}, s1_vld_r};
  assign credit   = (oq_used < (etdc_pkg::OQ_AW + 1)'(etdc_pkg::OQ_DEPTH - 1)) ||
                    (oq_used == (etdc_pkg::OQ_AW + 1)'(etdc_pkg::OQ_DEPTH - 1));
  assign cq_pop_o = !cq_empty_i && (cq_head_i.wr || credit);
  assign issue_wr = cq_pop_o && cq_head_i.wr && !cq_head_i.err;
  assign issue_rd = cq_pop_o && !cq_head_i.wr;
  assign addr     = etdc_pkg::TBL_AW'(cq_head_i.idx);

  always_ff @(posedge clk) begin
    if (issue_wr) begin
      vocab_mem[addr] <= cq_head_i.word;
    end
    if (issue_rd) begin
      rd_data_r <= vocab_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_rd) begin
      s1_idx_r <= cq_head_i.idx;
      s1_err_r <= cq_head_i.err;
    end
  end

  always_comb begin
    s1_res.word = s1_err_r ? 32'd0 : rd_data_r;
    s1_res.idx  = s1_idx_r;
    s1_res.err  = s1_err_r;
  end

  assign res_empty_o = (oq_cnt_r == '0);
  assign res_o       = oq_r[oq_rp_r];

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (s1_vld_r && !res_pop_i) begin
      oq_cnt_nxt = oq_cnt_r + 1'b1;
    end else if (!s1_vld_r && res_pop_i) begin
      oq_cnt_nxt = oq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (s1_vld_r) begin
        oq_wp_r <= oq_wp_r + 1'b1;
      end
      if (res_pop_i) begin
        oq_rp_r <= oq_rp_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      oq_r[oq_wp_r] <= s1_res;
    end
  end

  // credit scheme must keep the result queue from overflowing
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= (etdc_pkg::OQ_AW + 1)'(etdc_pkg::OQ_DEPTH))
    else $error("result queue over capacity");

  // every lookup issued is in the lookup stage next cycle, with queue room
  a_lookup_lands: assert property (@(posedge clk) disable iff (!rst_n)
    issue_rd |=> (s1_vld_r && oq_cnt_r < (etdc_pkg::OQ_AW + 1)'(etdc_pkg::OQ_DEPTH)))
    else $error("lookup issued without result space");

endmodule

FILE: dv/tb.sv
// self-checking testbench for the end-tagged dense code decoder: directed script, then random phases
module tb;

  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 150;
  localparam int LEN3_TOP     = 2113663;

  typedef struct packed {
    logic        mode;
    logic [15:0] entry_index;
    logic [31:0] entry_word;
    logic [7:0]  code_byte;
  } code_item_t;

  typedef enum {ROW_LOAD, ROW_BYTE, ROW_SIZE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] arg;
    logic [31:0] word;
    bit          typed;
    logic [31:0] want_word;
    logic [31:0] want_idx;
    logic        want_err;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic        push = 1'b0;
  logic        full;
  logic        in_mode = etdc_pkg::MODE_LOAD;
  logic [15:0] in_entry_index = '0;
  logic [31:0] in_entry_word = '0;
  logic [7:0]  in_code_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] out_decoded_word;
  logic [31:0] out_code_index;
  logic        out_index_error;

  // decoder state as the stimulus side sees it after every accepted transfer
  logic [31:0] digits = '0;
  logic [31:0] length_base = '0;
  logic [31:0] length_weight = 32'd128;
  logic [16:0] vocab_limit = '0;
  logic [31:0] vocab_mem [etdc_pkg::TABLE_DEPTH];
  bit          vocab_seen [etdc_pkg::TABLE_DEPTH];

  etdc_pkg::res_t awaited_words [$];
  int          mismatches = 0;
  int          items_sent = 0;
  bit          calm_tail = 1'b0;
  int          pop_gap = 0;

  // sizes 0 and 4 first, then the full table
  row_t script [27] = '{
    '{ROW_BYTE, 32'd128,     32'd0,          1'b1, 32'd0,          32'd0,         1'b1},
    '{ROW_SIZE, 32'd4,       32'd0,          1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_LOAD, 32'd0,       32'hFFFF_FFFF,  1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_LOAD, 32'd3,       32'hA5A5_5A5A,  1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_BYTE, 32'd128,     32'd0,          1'b1, 32'hFFFF_FFFF,  32'd0,         1'b0},
    '{ROW_BYTE, 32'd131,     32'd0,          1'b1, 32'hA5A5_5A5A,  32'd3,         1'b0},
    '{ROW_BYTE, 32'd132,     32'd0,          1'b1, 32'd0,          32'd4,         1'b1},
    '{ROW_BYTE, 32'd255,     32'd0,          1'b1, 32'd0,          32'd127,       1'b1},
    '{ROW_BYTE, 32'd0,       32'd0,          1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_BYTE, 32'd128,     32'd0,          1'b1, 32'd0,          32'd128,       1'b1},
    '{ROW_BYTE, 32'd127,     32'd0,          1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_BYTE, 32'd127,     32'd0,          1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_BYTE, 32'd127,     32'd0,          1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_BYTE, 32'd127,     32'd0,          1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_BYTE, 32'd127,     32'd0,          1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_BYTE, 32'd255,     32'd0,          1'b1, 32'd0,          32'hFFFF_FFFF, 1'b1},
    '{ROW_LOAD, 32'hFFFF,    32'h1234_5678,  1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_SIZE, 32'd65536,   32'd0,          1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_BYTE, 32'd2,       32'd0,          1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_BYTE, 32'd126,     32'd0,          1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_BYTE, 32'd255,     32'd0,          1'b1, 32'h1234_5678,  32'd65535,     1'b0},
    '{ROW_BYTE, 32'd0,       32'd0,          1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_LOAD, 32'd128,     32'h0000_0001,  1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_BYTE, 32'd128,     32'd0,          1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_BYTE, 32'd2,       32'd0,          1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_BYTE, 32'd127,     32'd0,          1'b0, 32'd0,          32'd0,         1'b0},
    '{ROW_BYTE, 32'd128,     32'd0,          1'b1, 32'd0,          32'h0001_0000, 1'b1}
  };

  end_tagged_dense_code_decoder_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .push            (push),
    .full            (full),
    .in_mode         (in_mode),
    .in_entry_index  (in_entry_index),
    .in_entry_word   (in_entry_word),
    .in_code_byte    (in_code_byte),
    .empty           (empty),
    .pop             (pop),
    .out_decoded_word(out_decoded_word),
    .out_code_index  (out_code_index),
    .out_index_error (out_index_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] clip32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // one saturation at the end equals the nested ones since every term is non-negative
  function automatic logic [31:0] dense_index(input logic [7:0] end_byte);
    return clip32((64'(digits) << 7) + 64'(length_base) + 64'(end_byte) -
                  64'(etdc_pkg::END_MARK));
  endfunction

  function automatic bit index_ok(input logic [31:0] idx);
    return (idx < vocab_limit) && (idx < etdc_pkg::TABLE_DEPTH);
  endfunction

  function automatic bit advance_decoder(input code_item_t it, output etdc_pkg::res_t got);
    logic [31:0] idx;
    got = '0;
    if (it.mode == etdc_pkg::MODE_LOAD) begin
      vocab_mem[it.entry_index] = it.entry_word;
      vocab_seen[it.entry_index] = 1'b1;
      return 1'b0;
    end
    if (it.code_byte < etdc_pkg::END_MARK) begin
      digits = clip32((64'(digits) << 7) + 64'(it.code_byte));
      length_base = clip32(64'(length_base) + 64'(length_weight));
      length_weight = clip32(64'(length_weight) << 7);
      return 1'b0;
    end
    idx = dense_index(it.code_byte);
    got.idx = idx;
    got.err = !index_ok(idx);
    got.word = got.err ? 32'd0 : vocab_mem[idx[15:0]];
    digits = '0;
    length_base = '0;
    length_weight = 32'd128;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s expected %h got %h", $time, what, want, got);
  endtask

  // called at a rising edge; returns at the edge that takes the transfer
  task automatic send_item(input code_item_t it, input bit use_typed,
                           input etdc_pkg::res_t typed_res);
    etdc_pkg::res_t got;
    if (!calm_tail && $urandom_range(0, 11) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_mode        <= it.mode;
    in_entry_index <= it.entry_index;
    in_entry_word  <= it.entry_word;
    in_code_byte   <= it.code_byte;
    push           <= 1'b1;
    do @(posedge clk); while (full);
    items_sent++;
    if (advance_decoder(it, got))
      awaited_words.push_back(use_typed ? typed_res : got);
  endtask

  task automatic send_load(input logic [15:0] idx, input logic [31:0] word);
    code_item_t it;
    it = '{mode: etdc_pkg::MODE_LOAD, entry_index: idx, entry_word: word,
           code_byte: 8'($urandom)};
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_random_load();
    logic [15:0] idx;
    if ($urandom_range(0, 1) == 0 || vocab_limit < 2)
      idx = 16'($urandom_range(0, 65535));
    else
      idx = 16'($urandom_range(0, vocab_limit - 1));
    send_load(idx, $urandom);
  endtask

  task automatic send_code_byte(input logic [7:0] b);
    code_item_t  it;
    logic [31:0] idx;
    if ($urandom_range(0, 15) == 0)
      send_random_load();
    // a valid lookup of a never-loaded entry is not allowed, so load it first
    if (b >= etdc_pkg::END_MARK) begin
      idx = dense_index(b);
      if (index_ok(idx) && !vocab_seen[idx[15:0]])
        send_load(idx[15:0], $urandom);
    end
    it = '{mode: etdc_pkg::MODE_DECODE, entry_index: 16'($urandom), entry_word: $urandom,
           code_byte: b};
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_codeword(input int unsigned target);
    int unsigned r;
    if (target < 128) begin
      send_code_byte(8'(128 + target));
    end else if (target < 16512) begin
      r = target - 128;
      send_code_byte(8'(r >> 7));
      send_code_byte(8'(128 + (r & 127)));
    end else begin
      r = target - 16512;
      send_code_byte(8'(r >> 14));
      send_code_byte(8'((r >> 7) & 127));
      send_code_byte(8'(128 + (r & 127)));
    end
  endtask

  task automatic set_vocab_size(input logic [16:0] size);
    push <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    // continuing bytes may still sit in the block without any result due
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    vocab_limit = size;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [16:0] size, input int count);
    int          stop_at;
    int unsigned pick;
    int unsigned n;
    set_vocab_size(size);
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_random_load();
      end else if (pick < 85) begin
        if (vocab_limit != 0 && $urandom_range(0, 4) != 0)
          send_codeword($urandom_range(0, vocab_limit - 1));
        else
          send_codeword($urandom_range(0, LEN3_TOP));
      end else begin
        // overlong or broken codewords, often driving the sums into saturation
        n = $urandom_range(1, 7);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0)
            send_code_byte(8'($urandom_range(0, 255)));
          else
            send_code_byte(8'($urandom_range(0, 127)));
        end
        send_code_byte(8'($urandom_range(128, 255)));
      end
    end
  endtask

  always @(posedge clk) begin : result_side
    etdc_pkg::res_t want;
    if (rst_n && pop && !empty) begin
      if (awaited_words.size() == 0) begin
        flag_mismatch("unexpected transfer, code_index", 32'd0, out_code_index);
      end else begin
        want = awaited_words.pop_front();
        if (out_decoded_word !== want.word)
          flag_mismatch("decoded_word", want.word, out_decoded_word);
        if (out_code_index !== want.idx)
          flag_mismatch("code_index", want.idx, out_code_index);
        if (out_index_error !== want.err)
          flag_mismatch("index_error", 32'(want.err), 32'(out_index_error));
      end
    end
    if (pop_gap > 0) begin
      pop_gap = pop_gap - 1;
      pop <= 1'b0;
    end else if (!calm_tail && $urandom_range(0, 15) == 0) begin
      pop_gap = $urandom_range(0, 16);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin : stimulus
    code_item_t     it;
    etdc_pkg::res_t typed_res;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (script[i]) begin
      typed_res = '{word: script[i].want_word, idx: script[i].want_idx,
                    err: script[i].want_err};
      case (script[i].kind)
        ROW_SIZE: begin
          set_vocab_size(script[i].arg[16:0]);
        end
        ROW_LOAD: begin
          it = '{mode: etdc_pkg::MODE_LOAD, entry_index: script[i].arg[15:0],
                 entry_word: script[i].word, code_byte: 8'h00};
          send_item(it, script[i].typed, typed_res);
        end
        default: begin
          it = '{mode: etdc_pkg::MODE_DECODE, entry_index: 16'h0000, entry_word: 32'h0,
                 code_byte: script[i].arg[7:0]};
          send_item(it, script[i].typed, typed_res);
        end
      endcase
    end
    run_phase(17'd65536, PHASE_ITEMS);
    run_phase(17'd1, PHASE_ITEMS);
    run_phase(17'd300, PHASE_ITEMS);
    run_phase(17'd16600, PHASE_ITEMS);
    run_phase(17'd0, PHASE_ITEMS);
    calm_tail = 1'b1;
    run_phase(17'($urandom_range(0, 65536)), PHASE_ITEMS);
    push <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin : watchdog
    #(20 * 400000);
    $display("Mismatches found");
    $finish;
  end

endmodule
